// File: rtl/total_energy_pitch_throttle_control_unit_macros.svh
// assertion macros for the total-energy pitch and throttle controller
// used by files that assert; expects clk and arst_n in scope
`ifndef TOTAL_ENERGY_PITCH_THROTTLE_CONTROL_UNIT_MACROS_SVH
`define TOTAL_ENERGY_PITCH_THROTTLE_CONTROL_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TEPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TEPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TEPC_ASSERT(lbl, prop, msg)
`define TEPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/tepc_pkg.sv
// shared widths, constants and control structs of the energy controller
// no dependencies
package tepc_pkg;
	localparam int INT_BITS  = 32;
	localparam int ERR_W     = 24;
	localparam int NUM_W     = 51;
	localparam int DEN_W     = 32;
	localparam int QUOT_W    = 25;
	localparam int MUL_A_W   = 25;
	localparam int MUL_B_W   = INT_BITS + 1;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CNT_W     = $clog2(QUOT_W);

	localparam logic [20:0] TWO_G_Q16 = 21'd1284506;
	localparam logic signed [20:0] LOW_ALT = 21'sd8;

	typedef enum logic [2:0] {
		REG_ENERGY_KP   = 3'd0,
		REG_ENERGY_KI   = 3'd1,
		REG_BALANCE_KP  = 3'd2,
		REG_BALANCE_KI  = 3'd3,
		REG_ALT_LIMIT   = 3'd4,
		REG_THR_LIMIT   = 3'd5,
		REG_THR_TRIM    = 3'd6,
		REG_PITCH_LIMIT = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_ctrl_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [ERR_W-1:0] quot;
	} div_stat_t;
endpackage

// File: rtl/tepc_cmd_if.sv
// request channel interfaces of the energy controller, input and result
// no dependencies
interface tepc_cmd_if;
	logic               valid;
	logic               ready;
	logic [15:0]        commanded_airspeed;
	logic [15:0]        measured_airspeed;
	logic signed [20:0] commanded_altitude;
	logic signed [20:0] measured_altitude;
	logic               clear_integrators;
	modport source(output valid, commanded_airspeed, measured_airspeed, commanded_altitude,
		measured_altitude, clear_integrators, input ready);
	modport sink(input valid, commanded_airspeed, measured_airspeed, commanded_altitude,
		measured_altitude, clear_integrators, output ready);
endinterface

interface tepc_rsp_if;
	logic               valid;
	logic               ready;
	logic [15:0]        throttle_cmd;
	logic signed [15:0] pitch_cmd;
	logic               zero_speed_ref;
	modport source(output valid, throttle_cmd, pitch_cmd, zero_speed_ref, input ready);
	modport sink(input valid, throttle_cmd, pitch_cmd, zero_speed_ref, output ready);
endinterface

// File: rtl/tepc_div.sv
// radix-2 restoring divider, signed numerator over unsigned denominator
// truncates toward zero and saturates to the error width; uses tepc_pkg
module tepc_div
	import tepc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  div_ctrl_t ctrl,
	output div_stat_t stat
);
	logic [DEN_W:0]    rem_q;
	logic [QUOT_W-1:0] mag_q;
	logic [QUOT_W-1:0] quot_q;
	logic [DEN_W-1:0]  den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q, ovf_q, busy_q, done_q;

	logic [NUM_W-1:0] mag_c;
	logic [DEN_W:0]   trial_c;
	logic [DEN_W:0]   diff_c;
	logic             fits_c;
	logic [QUOT_W-1:0] quot_n;

	assign mag_c   = ctrl.num[NUM_W-1] ? NUM_W'(-ctrl.num) : NUM_W'(ctrl.num);
	assign trial_c = {rem_q[DEN_W-1:0], mag_q[QUOT_W-1]};
	assign diff_c  = trial_c - {1'b0, den_q};
	assign fits_c  = trial_c >= {1'b0, den_q};
	assign quot_n  = {quot_q[QUOT_W-2:0], fits_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W - 1);
				den_q  <= ctrl.den;
				neg_q  <= ctrl.num[NUM_W-1];
				// quotient needs more than QUOT_W bits: saturated anyway
				ovf_q  <= {{(DEN_W-(NUM_W-1-QUOT_W)){1'b0}}, mag_c[NUM_W-2:QUOT_W]} >= ctrl.den;
				rem_q  <= (DEN_W+1)'(mag_c[NUM_W-2:QUOT_W]);
				mag_q  <= mag_c[QUOT_W-1:0];
				quot_q <= '0;
			end else if (busy_q) begin
				rem_q  <= fits_c ? diff_c : trial_c;
				mag_q  <= {mag_q[QUOT_W-2:0], 1'b0};
				quot_q <= quot_n;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_comb begin
		stat.busy = busy_q;
		stat.done = done_q;
		if (neg_q) begin
			if (ovf_q || quot_q > QUOT_W'(2**(ERR_W-1)))
				stat.quot = {1'b1, {(ERR_W-1){1'b0}}};
			else
				stat.quot = -ERR_W'(quot_q);
		end else begin
			if (ovf_q || quot_q > QUOT_W'(2**(ERR_W-1) - 1))
				stat.quot = {1'b0, {(ERR_W-1){1'b1}}};
			else
				stat.quot = ERR_W'(quot_q);
		end
	end
endmodule

// File: rtl/total_energy_pitch_throttle_control_unit.sv
// a request with zero commanded airspeed skips the energy terms and both divisions
// one request at a time: ready only while idle
// cost is set by two 25-step serial divisions by vc^2 and one shared multiplier
// a new request is taken while the previous result still waits in its register
// reset: gains and limits to defaults, integrators and last errors to zero
// depends on tepc_pkg, tepc_cmd_if, tepc_rsp_if, tepc_div and the macro header
`include "total_energy_pitch_throttle_control_unit_macros.svh"
module total_energy_pitch_throttle_control_unit
	import tepc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tepc_cmd_if.sink    cmd,
	tepc_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_SQ_VC, S_SQ_V, S_G, S_SUM, S_DIV_E, S_DIV_L, S_INTEG,
		S_KPE, S_KIE, S_THR, S_KIL, S_PIT
	} state_t;

	// configuration registers
	logic [23:0] ekp_q, eki_q, bkp_q, bki_q;
	logic [15:0] alt_lim_q, thr_lim_q, thr_trim_q;
	logic [14:0] pitch_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ekp_q       <= 24'd327680;
			eki_q       <= 24'd295;
			bkp_q       <= 24'd65536;
			bki_q       <= 24'd16;
			alt_lim_q   <= 16'd80;
			thr_lim_q   <= 16'd32768;
			thr_trim_q  <= 16'd16384;
			pitch_lim_q <= 15'd12868;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENERGY_KP:   ekp_q       <= cfg_data;
				REG_ENERGY_KI:   eki_q       <= cfg_data;
				REG_BALANCE_KP:  bkp_q       <= cfg_data;
				REG_BALANCE_KI:  bki_q       <= cfg_data;
				REG_ALT_LIMIT:   alt_lim_q   <= cfg_data[15:0];
				REG_THR_LIMIT:   thr_lim_q   <= cfg_data[15:0];
				REG_THR_TRIM:    thr_trim_q  <= cfg_data[15:0];
				REG_PITCH_LIMIT: pitch_lim_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	state_t state_q;

	// request operands
	logic [15:0]        vc_q, v_q;
	logic signed [16:0] dh_q;
	logic               clr_q, low_alt_q;
	logic [DEN_W-1:0]   vc2_q;
	logic signed [DEN_W:0] kdiff_q;
	logic signed [NUM_W-1:0] num_e_q, num_l_q;
	logic signed [ERR_W-1:0] e_q, l_q, e_last_q, l_last_q;
	logic signed [INT_BITS-1:0] ie_q, ib_q;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic [15:0] thr_q;

	// result register
	logic        rsp_valid_q, zero_q, rsp_zero_q;
	logic [15:0] rsp_thr_q;
	logic signed [15:0] rsp_pitch_q;

	// altitude error clamp at request time
	logic signed [21:0] dh_raw_c, lim_c;
	logic signed [16:0] dh_c;
	always_comb begin
		dh_raw_c = 22'(cmd.commanded_altitude) - 22'(cmd.measured_altitude);
		lim_c    = {6'b0, alt_lim_q};
		if (dh_raw_c > lim_c)       dh_c = 17'(lim_c);
		else if (dh_raw_c < -lim_c) dh_c = 17'(-lim_c);
		else                        dh_c = 17'(dh_raw_c);
	end

	// shared multiplier operand select
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ_VC: begin
				mul_a = MUL_A_W'({1'b0, vc_q});
				mul_b = MUL_B_W'({1'b0, vc_q});
			end
			S_SQ_V: begin
				mul_a = MUL_A_W'({1'b0, v_q});
				mul_b = MUL_B_W'({1'b0, v_q});
			end
			S_G: begin
				mul_a = MUL_A_W'({1'b0, TWO_G_Q16});
				mul_b = {{(MUL_B_W-17){dh_q[16]}}, dh_q};
			end
			S_KPE: begin
				mul_a = {1'b0, ekp_q};
				mul_b = {{(MUL_B_W-ERR_W){e_q[ERR_W-1]}}, e_q};
			end
			S_KIE: begin
				mul_a = {1'b0, eki_q};
				mul_b = {{(MUL_B_W-INT_BITS){ie_q[INT_BITS-1]}}, ie_q};
			end
			S_THR: begin
				mul_a = {1'b0, bkp_q};
				mul_b = {{(MUL_B_W-ERR_W){l_q[ERR_W-1]}}, l_q};
			end
			// product held steady while the result waits
			S_KIL, S_PIT: begin
				mul_a = {1'b0, bki_q};
				mul_b = {{(MUL_B_W-INT_BITS){ib_q[INT_BITS-1]}}, ib_q};
			end
			default: ;
		endcase
	end

	// energy numerators: kinetic term scaled by 2^16, potential term by 2^12
	logic signed [NUM_W-1:0] kn_c, un_c;
	assign kn_c = {{(NUM_W-DEN_W-17){kdiff_q[DEN_W]}}, kdiff_q, 16'b0};
	assign un_c = {prod_q[NUM_W-13:0], 12'b0};

	// divider shared by both errors
	div_ctrl_t div_ctrl;
	div_stat_t div_stat;
	always_comb begin
		div_ctrl.start = (state_q == S_SUM) || (state_q == S_DIV_E && div_stat.done);
		div_ctrl.num   = (state_q == S_SUM) ? kn_c + un_c : num_l_q;
		div_ctrl.den   = vc2_q;
	end

	tepc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.stat   (div_stat)
	);

	// saturating integrator updates
	localparam logic signed [INT_BITS+1:0] INT_MAX = {3'b000, {(INT_BITS-1){1'b1}}};
	localparam logic signed [INT_BITS+1:0] INT_MIN = {3'b111, {(INT_BITS-1){1'b0}}};
	logic signed [INT_BITS+1:0] ie_sum_c, ib_sum_c;
	logic signed [INT_BITS-1:0] ie_n, ib_n;
	always_comb begin
		ie_sum_c = (clr_q ? '0 : (INT_BITS+2)'(ie_q)) + (INT_BITS+2)'(e_q)
			+ (INT_BITS+2)'(e_last_q);
		ib_sum_c = (clr_q ? '0 : (INT_BITS+2)'(ib_q)) + (INT_BITS+2)'(l_q)
			+ (INT_BITS+2)'(l_last_q);
		if (ie_sum_c > INT_MAX)      ie_n = INT_BITS'(INT_MAX);
		else if (ie_sum_c < INT_MIN) ie_n = INT_BITS'(INT_MIN);
		else                         ie_n = INT_BITS'(ie_sum_c);
		if (ib_sum_c > INT_MAX)      ib_n = INT_BITS'(INT_MAX);
		else if (ib_sum_c < INT_MIN) ib_n = INT_BITS'(INT_MIN);
		else                         ib_n = INT_BITS'(ib_sum_c);
	end

	// pi sums: proportional product plus integral product, Q32
	logic signed [SUM_W-1:0] pi_sum_c;
	assign pi_sum_c = SUM_W'(acc_q) + SUM_W'(prod_q);

	// throttle: truncate to Q15, clamp to [0, limit], add trim, saturate
	logic [SUM_W-18:0] thr_sh_c;
	logic [15:0]       thr_sat_c;
	logic [16:0]       thr_trim_c;
	always_comb begin
		thr_sh_c = pi_sum_c[SUM_W-1:17];
		if (pi_sum_c <= 0)                         thr_sat_c = '0;
		else if (thr_sh_c > (SUM_W-17)'(thr_lim_q)) thr_sat_c = thr_lim_q;
		else                                       thr_sat_c = thr_sh_c[15:0];
		thr_trim_c = {1'b0, thr_sat_c} + {1'b0, thr_trim_q};
	end

	// pitch: truncate toward zero to Q14, clamp to +/- limit
	logic signed [SUM_W-1:0]  pit_rnd_c;
	logic signed [SUM_W-19:0] pit_sh_c;
	logic signed [SUM_W-19:0] plim_c;
	logic signed [15:0]       pit_c;
	always_comb begin
		pit_rnd_c = pi_sum_c + (pi_sum_c[SUM_W-1] ? SUM_W'(2**18 - 1) : '0);
		pit_sh_c  = pit_rnd_c[SUM_W-1:18];
		plim_c    = (SUM_W-18)'({1'b0, pitch_lim_q});
		if (pit_sh_c > plim_c)       pit_c = 16'(plim_c);
		else if (pit_sh_c < -plim_c) pit_c = 16'(-plim_c);
		else                         pit_c = 16'(pit_sh_c);
	end

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.throttle_cmd   = rsp_thr_q;
	assign rsp.pitch_cmd      = rsp_pitch_q;
	assign rsp.zero_speed_ref = rsp_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			ie_q        <= '0;
			ib_q        <= '0;
			e_last_q    <= '0;
			l_last_q    <= '0;
		end else begin
			// product register of the shared multiplier
			prod_q <= mul_a * mul_b;
			// result taken; the pitch state handles its own hand-over
			if (rsp_valid_q && rsp.ready && state_q != S_PIT)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						vc_q      <= cmd.commanded_airspeed;
						v_q       <= cmd.measured_airspeed;
						dh_q      <= dh_c;
						clr_q     <= cmd.clear_integrators;
						low_alt_q <= cmd.measured_altitude < LOW_ALT;
						state_q   <= S_SQ_VC;
					end
				end
				S_SQ_VC: begin
					zero_q <= (vc_q == '0);
					if (vc_q == '0) begin
						// zero speed reference: both errors forced to zero
						e_q     <= '0;
						l_q     <= '0;
						state_q <= S_INTEG;
					end else begin
						state_q <= S_SQ_V;
					end
				end
				S_SQ_V: begin
					vc2_q   <= prod_q[DEN_W-1:0];
					state_q <= S_G;
				end
				S_G: begin
					kdiff_q <= {1'b0, vc2_q} - {1'b0, prod_q[DEN_W-1:0]};
					state_q <= S_SUM;
				end
				S_SUM: begin
					num_l_q <= un_c - kn_c;
					state_q <= S_DIV_E;
				end
				S_DIV_E: begin
					if (div_stat.done) begin
						e_q     <= div_stat.quot;
						state_q <= S_DIV_L;
					end
				end
				S_DIV_L: begin
					if (div_stat.done) begin
						l_q     <= div_stat.quot;
						state_q <= S_INTEG;
					end
				end
				S_INTEG: begin
					ie_q     <= low_alt_q ? '0 : ie_n;
					ib_q     <= ib_n;
					e_last_q <= e_q;
					l_last_q <= l_q;
					state_q  <= S_KPE;
				end
				S_KPE: state_q <= S_KIE;
				S_KIE: begin
					acc_q   <= prod_q;
					state_q <= S_THR;
				end
				S_THR: begin
					thr_q   <= thr_trim_c[16] ? 16'hFFFF : thr_trim_c[15:0];
					state_q <= S_KIL;
				end
				S_KIL: begin
					acc_q   <= prod_q;
					state_q <= S_PIT;
				end
				S_PIT: begin
					// hold here while an older result is still unclaimed
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_thr_q   <= thr_q;
						rsp_pitch_q <= pit_c;
						rsp_zero_q  <= zero_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TEPC_ASSERT(a_no_accept_div_busy, !(cmd.ready && div_stat.busy), "request taken with divider busy")
	`TEPC_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready, "ready right after request")
	`TEPC_ASSERT(a_pitch_in_limit, !rsp_valid_q || (rsp_pitch_q <= $signed({1'b0, pitch_lim_q}) && rsp_pitch_q >= -$signed({1'b0, pitch_lim_q})), "pitch beyond limit")
	`TEPC_ASSERT(a_div_only_in_div, !div_stat.done || state_q == S_DIV_E || state_q == S_DIV_L, "divider done outside division")
endmodule
